[design/nmea_gga_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA GGA decoder package
// Character codes, header patterns, enum types and helpers shared by the
// sentence checker and its port checker.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

	// ASCII characters of interest
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	// offset from a nibble of 10..15 to 'A'..'F'
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

	// five header characters, first one in the high bits
	localparam logic [39:0] HDR_GGA = 40'h4750474741;
	localparam logic [39:0] HDR_VTG = 40'h4750565447;
	localparam logic [39:0] HDR_RMC = 40'h4750524D43;
	localparam logic [39:0] HDR_GSV = 40'h4750475356;

	localparam int unsigned HDR_LEN = 5;

	// GGA field indexes (commas before the field)
	localparam logic [4:0] FLD_LAT_DIR = 5'd3;
	localparam logic [4:0] FLD_LON_DIR = 5'd5;
	localparam logic [4:0] FLD_FIX     = 5'd6;
	localparam logic [4:0] FLD_SATS    = 5'd7;

	localparam logic [4:0] COMMA_MAX = 5'd31;

	typedef enum logic [2:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_GGA     = 3'd1,
		KIND_VTG     = 3'd2,
		KIND_RMC     = 3'd3,
		KIND_GSV     = 3'd4
	} kind_t;

	// where the parser stands after the '$'
	typedef enum logic [1:0] {
		TRL_BODY = 2'd0,
		TRL_HEX1 = 2'd1,
		TRL_HEX2 = 2'd2
	} trl_t;

	// what the next body byte means for field capture
	typedef enum logic [1:0] {
		DIG_NONE   = 2'd0,
		DIG_FIRST  = 2'd1,
		DIG_SECOND = 2'd2
	} dig_t;

	// uppercase hex ASCII of one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'd0, nib};
		if (nib <= 4'd9)
			return wide + CH_ZERO;
		else
			return wide + HEX_ALPHA_OFS;
	endfunction

	function automatic kind_t kind_of(input logic [7:0] body_len, input logic [39:0] hdr);
		kind_t k;
		k = KIND_UNKNOWN;
		if (body_len >= 8'(HDR_LEN)) begin
			if (hdr == HDR_GGA)      k = KIND_GGA;
			else if (hdr == HDR_VTG) k = KIND_VTG;
			else if (hdr == HDR_RMC) k = KIND_RMC;
			else if (hdr == HDR_GSV) k = KIND_GSV;
		end
		return k;
	endfunction

endpackage

[design/nmea_sentence_checker_gga_decoder.sv]
// ----------------------------------------------------------------------------
// NMEA sentence checker with GGA decode
// Checks the XOR checksum of NMEA 0183 sentences, classifies the header and
// keeps the fix, satellite count and hemisphere flags of checked GGA lines.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Width  Contents
// s_*       in   8      tdata: rx_byte
// m_*       out  48     tdata: echo_byte, field_number, checksum_good,
//                       computed_xor, fix_status, fix_valid, satellite_count,
//                       latitude_south, longitude_west
//                       tuser: sentence_kind   tlast: sentence_done
//
// One byte per cycle. Each accepted byte yields exactly one result
// transaction in the cycle after it is taken, from the parser state registers through a
// single level of decode logic into the output register.
// s_tready is low only while a result sits in the output register and the
// sink holds m_tready low; the next byte is taken in the cycle the result
// leaves. Reset clears all parser state, held GGA values and m_tvalid.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_gga_decoder #(
	parameter int unsigned MAX_BODY_BYTES = 100	// overlength limit, 16..255
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,	// [7:0] rx_byte

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,	// [7:0] echo_byte, [12:8] field_number,
	                            	// [13] checksum_good, [21:14] computed_xor,
	                            	// [29:22] fix_status, [30] fix_valid,
	                            	// [38:31] satellite_count, [39] latitude_south,
	                            	// [40] longitude_west, [47:41] zero
	output logic [2:0]  m_tuser,	// [2:0] sentence_kind
	output logic        m_tlast 	// sentence_done
);

	// ---------------------------------------------------------------- state
	logic                 inside_q;
	logic [7:0]           body_len_q;
	logic [7:0]           xor_q;
	logic [4:0]           comma_q;
	logic [39:0]          hdr_q;
	nmea_gga_pkg::trl_t   trl_q;
	logic [7:0]           first_hex_q;
	nmea_gga_pkg::dig_t   dig_q;
	logic [7:0]           pend_status_q;
	logic [7:0]           pend_sats_q;
	logic [1:0]           pend_dirs_q;	// bit0 south, bit1 west
	logic [7:0]           held_status_q;
	logic [7:0]           held_sats_q;
	logic [1:0]           held_dirs_q;

	// next values
	logic                 inside_d;
	logic [7:0]           body_len_d;
	logic [7:0]           xor_d;
	logic [4:0]           comma_d;
	logic [39:0]          hdr_d;
	nmea_gga_pkg::trl_t   trl_d;
	logic [7:0]           first_hex_d;
	nmea_gga_pkg::dig_t   dig_d;
	logic [7:0]           pend_status_d;
	logic [7:0]           pend_sats_d;
	logic [1:0]           pend_dirs_d;
	logic [7:0]           held_status_d;
	logic [7:0]           held_sats_d;
	logic [1:0]           held_dirs_d;
	logic                 done_d;
	logic                 good_d;

	// output register
	logic                 out_valid_q;
	logic [47:0]          out_data_q;
	logic [2:0]           out_kind_q;
	logic                 out_last_q;
	logic [47:0]          out_data_d;
	nmea_gga_pkg::kind_t  kind_d;

	logic                 take;
	logic [7:0]           b;
	logic [7:0]           b_digit;	// byte minus '0'
	logic [7:0]           body_inc;
	nmea_gga_pkg::kind_t  kind_cur;

	// Output register frees up in the same cycle its result is taken.
	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	assign b        = s_tdata;
	assign b_digit  = b - nmea_gga_pkg::CH_ZERO;
	assign body_inc = body_len_q + 8'd1;
	assign kind_cur = nmea_gga_pkg::kind_of(body_len_q, hdr_q);

	// ------------------------------------------------------ next-state logic
	always_comb begin
		inside_d      = inside_q;
		body_len_d    = body_len_q;
		xor_d         = xor_q;
		comma_d       = comma_q;
		hdr_d         = hdr_q;
		trl_d         = trl_q;
		first_hex_d   = first_hex_q;
		dig_d         = dig_q;
		pend_status_d = pend_status_q;
		pend_sats_d   = pend_sats_q;
		pend_dirs_d   = pend_dirs_q;
		held_status_d = held_status_q;
		held_sats_d   = held_sats_q;
		held_dirs_d   = held_dirs_q;
		done_d        = 1'b0;
		good_d        = 1'b0;

		if (b == nmea_gga_pkg::CH_DOLLAR) begin
			// restart; shadow copies start from the committed values
			inside_d      = 1'b1;
			body_len_d    = '0;
			xor_d         = '0;
			comma_d       = '0;
			hdr_d         = '0;
			trl_d         = nmea_gga_pkg::TRL_BODY;
			first_hex_d   = '0;
			dig_d         = nmea_gga_pkg::DIG_NONE;
			pend_status_d = held_status_q;
			pend_sats_d   = held_sats_q;
			pend_dirs_d   = held_dirs_q;
		end else if (inside_q) begin
			unique case (trl_q)
				nmea_gga_pkg::TRL_BODY: begin
					dig_d = nmea_gga_pkg::DIG_NONE;
					if (dig_q == nmea_gga_pkg::DIG_FIRST) begin
						case (comma_q)
							nmea_gga_pkg::FLD_LAT_DIR:
								pend_dirs_d[0] = (b == nmea_gga_pkg::CH_S);
							nmea_gga_pkg::FLD_LON_DIR:
								pend_dirs_d[1] = (b == nmea_gga_pkg::CH_W);
							nmea_gga_pkg::FLD_FIX:
								pend_status_d = b;
							nmea_gga_pkg::FLD_SATS: begin
								if (b == nmea_gga_pkg::CH_COMMA) begin
									pend_sats_d = '0;	// empty field
								end else begin
									pend_sats_d = 8'(b_digit * 8'd10);
									dig_d       = nmea_gga_pkg::DIG_SECOND;
								end
							end
							default: ;
						endcase
					end else if (dig_q == nmea_gga_pkg::DIG_SECOND) begin
						pend_sats_d = pend_sats_q + b_digit;
					end

					if (b == nmea_gga_pkg::CH_STAR) begin
						trl_d = nmea_gga_pkg::TRL_HEX1;
						dig_d = nmea_gga_pkg::DIG_NONE;
					end else begin
						xor_d = xor_q ^ b;
						if (body_len_q < 8'(nmea_gga_pkg::HDR_LEN))
							hdr_d = {hdr_q[31:0], b};
						body_len_d = body_inc;
						if (b == nmea_gga_pkg::CH_COMMA) begin
							if (comma_q < nmea_gga_pkg::COMMA_MAX)
								comma_d = comma_q + 5'd1;
							dig_d = nmea_gga_pkg::DIG_FIRST;
						end
						// overlength: no '*' in time
						if (body_inc >= 8'(MAX_BODY_BYTES)) begin
							done_d   = 1'b1;
							inside_d = 1'b0;
							dig_d    = nmea_gga_pkg::DIG_NONE;
						end
					end
				end
				nmea_gga_pkg::TRL_HEX1: begin
					first_hex_d = b;
					trl_d       = nmea_gga_pkg::TRL_HEX2;
				end
				nmea_gga_pkg::TRL_HEX2: begin
					done_d = 1'b1;
					good_d = (first_hex_q == nmea_gga_pkg::hex_char(xor_q[7:4])) &&
					         (b == nmea_gga_pkg::hex_char(xor_q[3:0]));
					if (good_d && kind_cur == nmea_gga_pkg::KIND_GGA) begin
						held_status_d = pend_status_q;
						held_sats_d   = pend_sats_q;
						held_dirs_d   = pend_dirs_q;
					end
					inside_d = 1'b0;
					trl_d    = nmea_gga_pkg::TRL_BODY;
				end
				default: begin
					trl_d = nmea_gga_pkg::TRL_BODY;
				end
			endcase
		end
	end

	// ---------------------------------------------------------- result logic
	always_comb begin
		kind_d     = nmea_gga_pkg::kind_of(body_len_d, hdr_d);
		out_data_d = '0;
		out_data_d[7:0]   = b;
		out_data_d[12:8]  = comma_d;
		out_data_d[13]    = good_d;
		out_data_d[21:14] = xor_d;
		out_data_d[29:22] = held_status_d;
		out_data_d[30]    = (held_status_d != nmea_gga_pkg::CH_ZERO);
		out_data_d[38:31] = held_sats_d;
		out_data_d[39]    = held_dirs_d[0];
		out_data_d[40]    = held_dirs_d[1];
	end

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q      <= 1'b0;
			body_len_q    <= '0;
			xor_q         <= '0;
			comma_q       <= '0;
			hdr_q         <= '0;
			trl_q         <= nmea_gga_pkg::TRL_BODY;
			first_hex_q   <= '0;
			dig_q         <= nmea_gga_pkg::DIG_NONE;
			pend_status_q <= '0;
			pend_sats_q   <= '0;
			pend_dirs_q   <= '0;
			held_status_q <= '0;
			held_sats_q   <= '0;
			held_dirs_q   <= '0;
		end else if (take) begin
			inside_q      <= inside_d;
			body_len_q    <= body_len_d;
			xor_q         <= xor_d;
			comma_q       <= comma_d;
			hdr_q         <= hdr_d;
			trl_q         <= trl_d;
			first_hex_q   <= first_hex_d;
			dig_q         <= dig_d;
			pend_status_q <= pend_status_d;
			pend_sats_q   <= pend_sats_d;
			pend_dirs_q   <= pend_dirs_d;
			held_status_q <= held_status_d;
			held_sats_q   <= held_sats_d;
			held_dirs_q   <= held_dirs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted byte
	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= out_data_d;
			out_kind_q <= kind_d;
			out_last_q <= done_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

[design/nmea_gga_checker.sv]
// ----------------------------------------------------------------------------
// NMEA GGA decoder port checker
// Port-level properties of the sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
module nmea_gga_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// an accepted byte comes out next cycle as the echo
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid && m_tdata[7:0] == $past(s_tdata))
		else $error("accepted byte not echoed on next result");

	// a good checksum only on the closing transaction
	a_good_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tlast)
		else $error("checksum_good without sentence_done");

	// fix_valid follows the held fix character
	a_fix_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30] == (m_tdata[29:22] != nmea_gga_pkg::CH_ZERO))
		else $error("fix_valid inconsistent with fix_status");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// kind codes stay below the first unused one
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= nmea_gga_pkg::KIND_GSV)
		else $error("sentence_kind out of range");

endmodule

bind nmea_sentence_checker_gga_decoder nmea_gga_checker u_nmea_gga_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[sim/nmea_sentence_checker_gga_decoder_test.sv]
// ----------------------------------------------------------------------------
// NMEA GGA decoder testbench
// Streams directed and randomized NMEA sentences through the checker while
// the source pauses in bursts and the sink stalls. Every result transaction
// is predicted and compared field by field.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_gga_decoder_test;

	localparam int unsigned BODY_LIMIT    = 100;	// overlength limit given to the DUT
	localparam int unsigned TARGET_BYTES  = 1080;	// random stimulus stops past this
	localparam int unsigned IDLE_LIMIT    = 4000;	// watchdog: cycles with no transaction
	localparam int unsigned SETTLE_CYCLES = 8;	// quiet time after the last result

	// how a generated sentence is closed
	typedef enum {
		END_GOOD,	// '*' and correct uppercase checksum
		END_LOWER,	// correct checksum in lowercase hex
		END_BAD,	// wrong checksum
		END_CUT	// no trailer; the next '$' abandons it
	} line_end_t;

	// one result transaction, unpacked
	typedef struct {
		logic [7:0]          echo;
		logic [4:0]          field_no;
		nmea_gga_pkg::kind_t kind;
		logic                done;
		logic                good;
		logic [7:0]          xsum;
		logic [7:0]          fix_char;
		logic                fix_ok;
		logic [7:0]          sats;
		logic                south;
		logic                west;
		logic [6:0]          pad;
	} report_t;

	// Sentence tracker: follows the parser byte by byte and keeps the
	// expected result transactions in arrival order.
	class nmea_line_scoreboard;
		report_t     expected_reports[$];
		int unsigned failures, checked;
		int unsigned good_lines, bad_lines, gga_commits;
		bit [4:0]    top_field;

		int unsigned        limit;
		bit                 in_line;
		bit [7:0]           body_len, xsum, hex_hi;
		bit [4:0]           commas;
		bit [39:0]          hdr;
		nmea_gga_pkg::trl_t trl;
		nmea_gga_pkg::dig_t dig;
		bit [7:0]           sh_fix, sh_sats;	// GGA captures of the current sentence
		bit [1:0]           sh_dirs;	// bit0 south, bit1 west
		bit [7:0]           fix_q, sats_q;	// committed values
		bit [1:0]           dirs_q;

		function new(int unsigned body_limit);
			limit = body_limit;
			trl   = nmea_gga_pkg::TRL_BODY;
			dig   = nmea_gga_pkg::DIG_NONE;
		endfunction

		// 0x37 + 10 is 'A', 0x57 + 10 is 'a'
		static function logic [7:0] hex_ascii(logic [3:0] nib, bit lower);
			if (nib <= 4'd9)
				return nmea_gga_pkg::CH_ZERO + nib;
			return (lower ? 8'h57 : 8'h37) + nib;
		endfunction

		function nmea_gga_pkg::kind_t line_kind();
			if (body_len < nmea_gga_pkg::HDR_LEN)
				return nmea_gga_pkg::KIND_UNKNOWN;
			case (hdr)
				nmea_gga_pkg::HDR_GGA: return nmea_gga_pkg::KIND_GGA;
				nmea_gga_pkg::HDR_VTG: return nmea_gga_pkg::KIND_VTG;
				nmea_gga_pkg::HDR_RMC: return nmea_gga_pkg::KIND_RMC;
				nmea_gga_pkg::HDR_GSV: return nmea_gga_pkg::KIND_GSV;
				default:               return nmea_gga_pkg::KIND_UNKNOWN;
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			report_t            r;
			nmea_gga_pkg::dig_t nxt;
			bit [7:0]           d;
			bit                 done, good;
			done = 1'b0;
			good = 1'b0;
			if (b == nmea_gga_pkg::CH_DOLLAR) begin
				// restart; captures start from the committed values
				in_line  = 1'b1;
				body_len = '0;
				xsum     = '0;
				commas   = '0;
				hdr      = '0;
				hex_hi   = '0;
				trl      = nmea_gga_pkg::TRL_BODY;
				dig      = nmea_gga_pkg::DIG_NONE;
				sh_fix   = fix_q;
				sh_sats  = sats_q;
				sh_dirs  = dirs_q;
			end else if (in_line) begin
				case (trl)
					nmea_gga_pkg::TRL_BODY: begin
						nxt = nmea_gga_pkg::DIG_NONE;
						d   = b - nmea_gga_pkg::CH_ZERO;
						if (dig == nmea_gga_pkg::DIG_FIRST) begin
							case (commas)
								nmea_gga_pkg::FLD_LAT_DIR:
									sh_dirs[0] = (b == nmea_gga_pkg::CH_S);
								nmea_gga_pkg::FLD_LON_DIR:
									sh_dirs[1] = (b == nmea_gga_pkg::CH_W);
								nmea_gga_pkg::FLD_FIX:
									sh_fix = b;
								nmea_gga_pkg::FLD_SATS: begin
									if (b == nmea_gga_pkg::CH_COMMA) begin
										sh_sats = '0;
									end else begin
										sh_sats = 8'(d * 8'd10);
										nxt = nmea_gga_pkg::DIG_SECOND;
									end
								end
								default: ;
							endcase
						end else if (dig == nmea_gga_pkg::DIG_SECOND) begin
							sh_sats = sh_sats + d;
						end
						dig = nxt;
						if (b == nmea_gga_pkg::CH_STAR) begin
							trl = nmea_gga_pkg::TRL_HEX1;
							dig = nmea_gga_pkg::DIG_NONE;
						end else begin
							xsum ^= b;
							if (body_len < nmea_gga_pkg::HDR_LEN)
								hdr = {hdr[31:0], b};
							body_len++;
							if (b == nmea_gga_pkg::CH_COMMA) begin
								if (commas != nmea_gga_pkg::COMMA_MAX)
									commas++;
								dig = nmea_gga_pkg::DIG_FIRST;
							end
							if (body_len >= limit) begin
								done    = 1'b1;
								in_line = 1'b0;
								dig     = nmea_gga_pkg::DIG_NONE;
							end
						end
					end
					nmea_gga_pkg::TRL_HEX1: begin
						hex_hi = b;
						trl = nmea_gga_pkg::TRL_HEX2;
					end
					default: begin
						done = 1'b1;
						good = (hex_hi == hex_ascii(xsum[7:4], 1'b0)) &&
							(b == hex_ascii(xsum[3:0], 1'b0));
						if (good && line_kind() == nmea_gga_pkg::KIND_GGA) begin
							fix_q  = sh_fix;
							sats_q = sh_sats;
							dirs_q = sh_dirs;
							gga_commits++;
						end
						in_line = 1'b0;
						trl = nmea_gga_pkg::TRL_BODY;
					end
				endcase
			end

			if (done && good)
				good_lines++;
			else if (done)
				bad_lines++;
			if (commas > top_field)
				top_field = commas;

			r.echo     = b;
			r.field_no = commas;
			r.kind     = line_kind();
			r.done     = done;
			r.good     = good;
			r.xsum     = xsum;
			r.fix_char = fix_q;
			r.fix_ok   = (fix_q != nmea_gga_pkg::CH_ZERO);
			r.sats     = sats_q;
			r.south    = dirs_q[0];
			r.west     = dirs_q[1];
			r.pad      = '0;
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("mismatch on result %0d, %s: expected %h, got %h",
						checked, name, want, got);
			end
		endfunction

		function void check_result(logic [47:0] data, logic [2:0] user, logic last);
			report_t got, want;
			got.echo     = data[7:0];
			got.field_no = data[12:8];
			got.good     = data[13];
			got.xsum     = data[21:14];
			got.fix_char = data[29:22];
			got.fix_ok   = data[30];
			got.sats     = data[38:31];
			got.south    = data[39];
			got.west     = data[40];
			got.pad      = data[47:41];
			got.kind     = nmea_gga_pkg::kind_t'(user);
			got.done     = last;
			if (expected_reports.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result transaction with nothing expected: tdata %h", data);
				return;
			end
			want = expected_reports.pop_front();
			compare_field("echo_byte",       want.echo,         got.echo);
			compare_field("field_number",    8'(want.field_no), 8'(got.field_no));
			compare_field("sentence_kind",   {5'd0, want.kind}, {5'd0, got.kind});
			compare_field("sentence_done",   8'(want.done),     8'(got.done));
			compare_field("checksum_good",   8'(want.good),     8'(got.good));
			compare_field("computed_xor",    want.xsum,         got.xsum);
			compare_field("fix_status",      want.fix_char,     got.fix_char);
			compare_field("fix_valid",       8'(want.fix_ok),   8'(got.fix_ok));
			compare_field("satellite_count", want.sats,         got.sats);
			compare_field("latitude_south",  8'(want.south),    8'(got.south));
			compare_field("longitude_west",  8'(want.west),     8'(got.west));
			compare_field("tdata padding",   8'(want.pad),      8'(got.pad));
			checked++;
		endfunction
	endclass

	// DUT ports; every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	nmea_line_scoreboard sb;
	logic [7:0]  body_q[$];	// body of the sentence being assembled
	int unsigned bytes_sent;
	int unsigned burst_left;
	int unsigned idle_cycles;
	int unsigned rx_mode, rx_mode_left, rx_phase;

	nmea_sentence_checker_gga_decoder #(
		.MAX_BODY_BYTES(BODY_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sink: a stall pattern that switches at random intervals between
	// always ready, mostly ready, a fixed 2-of-5 duty cycle and coin flips.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(30, 300);
		end else begin
			rx_mode_left--;
		end
		rx_phase++;
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= ((rx_phase % 5) < 2);
			default: m_tready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	// Result monitor and idle counter. Values read here are the ones that
	// stood before the edge, so a transaction is seen exactly once.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, sb.expected_reports.size());
		$display("status: fail");
		$finish;
	end

	// Source: bursts of random length, random gaps in between. Called at a
	// rising edge; returns at the edge where the byte was taken.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// hold the source off until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// printable, never a delimiter
	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (c == nmea_gga_pkg::CH_DOLLAR || c == nmea_gga_pkg::CH_STAR ||
			c == nmea_gga_pkg::CH_COMMA);
		return c;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_q.push_back(s[i]);
	endfunction

	function automatic void push_rand(input int unsigned n);
		repeat (n) body_q.push_back(text_char());
	endfunction

	function automatic void push_digits(input int unsigned n);
		repeat (n) body_q.push_back(nmea_gga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// GGA line with the captured fields varied: hemisphere letters present,
	// absent or odd; fix empty or any character; satellites empty, one or
	// two digits or non-digits. Sometimes the line ends at the satellite
	// field so that '*' lands as its second digit.
	function automatic void build_gga();
		push_text("GPGGA,");
		push_digits($urandom_range(0, 6));
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		push_digits($urandom_range(0, 4));
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		case ($urandom_range(0, 3))
			0:       push_text("N");
			1:       push_text("S");
			2:       ;
			default: push_rand(1);
		endcase
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		push_digits($urandom_range(0, 5));
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		case ($urandom_range(0, 3))
			0:       push_text("E");
			1:       push_text("W");
			2:       ;
			default: push_rand(1);
		endcase
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		case ($urandom_range(0, 4))
			0:       push_text("0");
			1:       push_text("1");
			2:       push_text("2");
			3:       ;
			default: push_rand(1);
		endcase
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		case ($urandom_range(0, 4))
			0:       ;
			1:       push_digits(1);
			2:       push_digits(2);
			3:       push_rand(2);
			default: push_rand(1);
		endcase
		if ($urandom_range(0, 5) == 0)
			return;
		body_q.push_back(nmea_gga_pkg::CH_COMMA);
		repeat ($urandom_range(0, 4)) begin
			push_rand($urandom_range(0, 3));
			body_q.push_back(nmea_gga_pkg::CH_COMMA);
		end
	endfunction

	// the other known headers, unknown and near-miss headers, short headers
	function automatic void build_other();
		case ($urandom_range(0, 5))
			0: push_text("GPVTG");
			1: push_text("GPRMC");
			2: push_text("GPGSV");
			3: push_rand(5);
			4: begin
				push_text("GPGG");
				push_rand(1);
			end
			default: begin
				push_rand($urandom_range(0, 4));
				return;
			end
		endcase
		repeat ($urandom_range(0, 8)) begin
			body_q.push_back(nmea_gga_pkg::CH_COMMA);
			push_rand($urandom_range(0, 4));
		end
	endfunction

	// more commas than the field index can count
	function automatic void build_crowded();
		push_text("GPGGA");
		repeat ($urandom_range(32, 45)) begin
			body_q.push_back(nmea_gga_pkg::CH_COMMA);
			if ($urandom_range(0, 2) == 0)
				push_rand(1);
		end
	endfunction

	// body of 99 to 110 bytes: just under or past the overlength limit
	function automatic void build_long();
		push_text("GPGGA");
		repeat ($urandom_range(BODY_LIMIT - 6, BODY_LIMIT + 5)) begin
			if ($urandom_range(0, 4) == 0)
				body_q.push_back(nmea_gga_pkg::CH_COMMA);
			else
				body_q.push_back(text_char());
		end
	endfunction

	task automatic send_line(input line_end_t how);
		logic [7:0] sum, wrong;
		sum = '0;
		foreach (body_q[i])
			sum ^= body_q[i];
		send_byte(nmea_gga_pkg::CH_DOLLAR);
		foreach (body_q[i])
			send_byte(body_q[i]);
		body_q.delete();
		case (how)
			END_GOOD: begin
				send_byte(nmea_gga_pkg::CH_STAR);
				send_byte(nmea_line_scoreboard::hex_ascii(sum[7:4], 1'b0));
				send_byte(nmea_line_scoreboard::hex_ascii(sum[3:0], 1'b0));
			end
			END_LOWER: begin
				send_byte(nmea_gga_pkg::CH_STAR);
				send_byte(nmea_line_scoreboard::hex_ascii(sum[7:4], 1'b1));
				send_byte(nmea_line_scoreboard::hex_ascii(sum[3:0], 1'b1));
			end
			END_BAD: begin
				wrong = sum ^ 8'($urandom_range(1, 255));
				send_byte(nmea_gga_pkg::CH_STAR);
				send_byte(nmea_line_scoreboard::hex_ascii(wrong[7:4], 1'b0));
				send_byte(nmea_line_scoreboard::hex_ascii(wrong[3:0], 1'b0));
			end
			default: ;
		endcase
		// line ending, ignored outside a sentence
		if ($urandom_range(0, 2) == 0) begin
			send_byte(8'h0D);
			send_byte(8'h0A);
		end
	endtask

	initial begin
		int unsigned pick, roll;
		line_end_t   how;
		bit          long_done, crowd_done, drained;

		sb = new(BODY_LIMIT);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Bytes outside any sentence: both byte extremes and the delimiters.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("*,");
		// short header with a good checksum: kind stays unknown
		send_text("$AB*03");
		// lowercase hex digit never matches
		send_text("$J*4a");
		// '$' in the middle abandons the sentence, the new one checks good
		send_text("$X$Y*59");

		// Random part: mostly well-formed sentences with random content,
		// some broken trailers, noise, and cut sentences left for the next '$'.
		while (bytes_sent < TARGET_BYTES) begin
			pick = $urandom_range(0, 99);
			roll = $urandom_range(0, 99);
			how  = (roll < 78) ? END_GOOD :
				(roll < 87) ? END_LOWER :
				(roll < 95) ? END_BAD : END_CUT;
			if (!crowd_done && bytes_sent > 250) begin
				build_crowded();
				crowd_done = 1'b1;
				send_line(how);
			end else if (!long_done && bytes_sent > 600) begin
				build_long();
				long_done = 1'b1;
				send_line(END_GOOD);
			end else if (pick < 52) begin
				build_gga();
				send_line(how);
			end else if (pick < 74) begin
				build_other();
				send_line(how);
			end else if (pick < 77) begin
				build_crowded();
				send_line(how);
			end else if (pick < 79) begin
				build_long();
				send_line(END_GOOD);
			end else begin
				// raw noise, '$' included now and then
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)));
			end

			// let the output run dry: once for sure, then now and then
			if ((!drained && bytes_sent > 400) || $urandom_range(0, 29) == 0) begin
				drain_results();
				drained = 1'b1;
			end
		end

		s_tvalid <= 1'b0;
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d bytes, %0d results: %0d sentences good, %0d rejected",
			bytes_sent, sb.checked, sb.good_lines, sb.bad_lines);
		$display("GGA values committed %0d times, field index reached %0d",
			sb.gga_commits, sb.top_field);
		if (sb.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
